// ===== hdl/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types, sizes and codes of the cursor sequence buffer.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int WORD_BITS   = 64;

  // field widths of the channels
  localparam int MODE_W       = 3;
  localparam int VALUE_W      = 64;
  localparam int ITEM_COUNT_W = 6;

  // internal sizes
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [MODE_W-1:0] MODE_START   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_ADVANCE = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_INSERT  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_ATTACH  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_REMOVE  = MODE_W'(4);

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic                    has_current;
    logic [VALUE_W-1:0]      current_value;
    logic [ITEM_COUNT_W-1:0] item_count;
    logic                    refused;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SH_FIRST,
    ST_SH_MORE,
    ST_DRAIN,
    ST_PUT,
    ST_FETCH,
    ST_RESP
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift_first;
    logic shift_more;
    logic drain;
    logic put;
    logic fetch;
    logic respond;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic move_any;
    logic write_word;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/csb_channels.sv =====
// ----------------------------------------------------------------------------
// csb channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface csb_cmd_if;
  import csb_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csb_res_if;
  import csb_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/csb_ram.sv =====
// ----------------------------------------------------------------------------
// csb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/csb_datapath.sv =====
// ----------------------------------------------------------------------------
// csb_datapath
// Entry store, count, cursor, move indexes and the result register.
// ----------------------------------------------------------------------------
module csb_datapath (
  input  logic           clk,
  input  logic           rst,
  input  csb_pkg::cmd_t  cmd_data,
  input  csb_pkg::ctl_t  ctl,
  output csb_pkg::stat_t stat,
  csb_res_if.source      res
);
  import csb_pkg::*;

  logic [CW-1:0]        count;
  logic [CW-1:0]        cursor;
  logic [WORD_BITS-1:0] word;
  logic                 refused;
  logic                 move_any;
  logic                 move_up;
  logic                 write_word;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        src;
  logic [AW-1:0]        stop;
  logic [AW-1:0]        wdst;
  logic                 out_valid;
  res_t                 out_data;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [CW-1:0]        ins_pos;
  logic                 has_cur;

  // slot where a new word lands, for insert and attach
  always_comb begin
    if (cmd_data.mode == MODE_INSERT) begin
      ins_pos = (cursor == '0) ? '0 : cursor - CW'(1);
    end else begin
      ins_pos = (cursor == '0) ? count : cursor;
    end
  end

  assign has_cur = (cursor != '0);

  // count and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else if (ctl.load) begin
      case (cmd_data.mode)
        MODE_START: begin
          if (count != '0) cursor <= CW'(1);
        end
        MODE_ADVANCE: begin
          if (has_cur) cursor <= (cursor < count) ? cursor + CW'(1) : '0;
        end
        MODE_INSERT, MODE_ATTACH: begin
          if (count != CW'(MAX_ENTRIES)) begin
            count  <= count + CW'(1);
            cursor <= ins_pos + CW'(1);
          end
        end
        MODE_REMOVE: begin
          if (has_cur) begin
            count <= count - CW'(1);
            if (cursor == count) cursor <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-command plan and move indexes
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      refused    <= 1'b0;
      move_any   <= 1'b0;
      write_word <= 1'b0;
      word       <= cmd_data.entry_value[WORD_BITS-1:0];
      case (cmd_data.mode)
        MODE_INSERT, MODE_ATTACH: begin
          if (count == CW'(MAX_ENTRIES)) begin
            refused <= 1'b1;
          end else begin
            write_word <= 1'b1;
            pos        <= AW'(ins_pos);
            move_up    <= 1'b1;
            move_any   <= (count > ins_pos);
            src        <= AW'(count - CW'(1));
            stop       <= AW'(ins_pos);
          end
        end
        MODE_REMOVE: begin
          if (has_cur) begin
            move_up  <= 1'b0;
            move_any <= (cursor < count);
            src      <= AW'(cursor);
            stop     <= AW'(count - CW'(1));
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.shift_first || ctl.shift_more) begin
      wdst <= move_up ? src + AW'(1) : src - AW'(1);
      src  <= move_up ? src - AW'(1) : src + AW'(1);
    end
  end

  assign stat.move_any   = move_any;
  assign stat.write_word = write_word;
  assign stat.last       = (src == stop);
  assign stat.out_free   = !out_valid || res.ready;

  // write port: moved word, or the new word
  always_comb begin
    ram_we    = ctl.shift_more || ctl.drain || ctl.put;
    ram_waddr = ctl.put ? pos : wdst;
    ram_wdata = ctl.put ? word : ram_rdata;
    ram_re    = ctl.shift_first || ctl.shift_more || ctl.fetch;
    ram_raddr = ctl.fetch ? AW'(cursor - CW'(1)) : src;
  end

  csb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.respond) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      out_data.has_current   <= has_cur;
      out_data.current_value <= has_cur ? VALUE_W'(ram_rdata) : '0;
      out_data.item_count    <= ITEM_COUNT_W'(count);
      out_data.refused       <= refused;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule

// ===== hdl/csb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csb_ctrl
// Sequencer: accept, plan, move entries, write the new word, read back, report.
// ----------------------------------------------------------------------------
module csb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  csb_pkg::stat_t stat,
  output csb_pkg::ctl_t  ctl
);
  import csb_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        // no transfer while reset is held
        cmd_ready = !rst;
        if (cmd_valid && !rst) begin
          ctl.load   = 1'b1;
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        if (stat.move_any) state_next = ST_SH_FIRST;
        else if (stat.write_word) state_next = ST_PUT;
        else state_next = ST_FETCH;
      end
      ST_SH_FIRST: begin
        ctl.shift_first = 1'b1;
        state_next      = stat.last ? ST_DRAIN : ST_SH_MORE;
      end
      ST_SH_MORE: begin
        ctl.shift_more = 1'b1;
        if (stat.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        ctl.drain  = 1'b1;
        state_next = stat.write_word ? ST_PUT : ST_FETCH;
      end
      ST_PUT: begin
        ctl.put    = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          ctl.respond = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cursor_sequence_buffer.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_buffer
// Ordered buffer of words with a cursor: start, advance, insert, attach, remove.
//
//   port  dir  payload                                           items
//   cmd   in   mode, entry_value                                 one command
//   res   out  has_current, current_value, item_count, refused   one per command
//
// a command is planned, then moves any stored words (first shift, further
// shifts, drain), writes the new word if any, reads back and reports;
// one read and one write per cycle on the store carry the word moves
// one command at a time; the next is taken once the result is loaded
// the result register lets a command be taken while the result waits
// reset clears count, cursor and the result valid; the store needs no clearing
// ----------------------------------------------------------------------------
module cursor_sequence_buffer (
  input logic       clk,
  input logic       rst,
  csb_cmd_if.sink   cmd,
  csb_res_if.source res
);
  import csb_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  csb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  csb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd_data (cmd.data),
    .ctl      (ctl),
    .stat     (stat),
    .res      (res)
  );

endmodule

// ===== hdl/csb_checker.sv =====
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks of the cursor sequence buffer results.
// ----------------------------------------------------------------------------
module csb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic                             res_has_current,
  input logic [csb_pkg::VALUE_W-1:0]      res_current_value,
  input logic [csb_pkg::ITEM_COUNT_W-1:0] res_item_count,
  input logic                             res_refused
);
  import csb_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_has_current)
      && $stable(res_current_value) && $stable(res_item_count) && $stable(res_refused))
    else $error("result changed while stalled");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_has_current |-> res_current_value == '0)
    else $error("value without current entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item_count <= ITEM_COUNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_refused |-> res_item_count == ITEM_COUNT_W'(MAX_ENTRIES))
    else $error("refused while not full");

  a_current_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_has_current |-> res_item_count != '0)
    else $error("current entry in empty buffer");

endmodule

bind cursor_sequence_buffer csb_checker u_csb_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_has_current   (res.data.has_current),
  .res_current_value (res.data.current_value),
  .res_item_count    (res.data.item_count),
  .res_refused       (res.data.refused)
);
